// ===== hw/rtl/ccc_pkg.sv =====
`timescale 1ns / 1ps

package ccc_pkg;

	// pixel channel and derived widths
	localparam int CH_W  = 8;
	localparam int SUM_W = 10;  // b+g+r <= 765
	localparam int THR_W = 11;
	localparam int PROD_THR_W = THR_W + SUM_W;

	// register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_MARKER_ONE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MARKER_TWO   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MARKER_THREE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_JOINT_REF    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GROW_THR     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SEED_THR     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_JOINT_THR    = 3'd6;

	// reset values, truncated to the reference width at the use site
	localparam logic [31:0] RST_MARKER_ONE   = 32'd87510;
	localparam logic [31:0] RST_MARKER_TWO   = 32'd129710;
	localparam logic [31:0] RST_MARKER_THREE = 32'd83005;
	localparam logic [31:0] RST_JOINT_REF    = 32'd705745;
	localparam logic [THR_W-1:0] RST_GROW_THR  = 11'd154;
	localparam logic [THR_W-1:0] RST_SEED_THR  = 11'd72;
	localparam logic [THR_W-1:0] RST_JOINT_THR = 11'd154;

	// class codes
	localparam int CLS_W = 2;
	localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_ONE   = 2'd1;
	localparam logic [CLS_W-1:0] CLS_TWO   = 2'd2;
	localparam logic [CLS_W-1:0] CLS_THREE = 2'd3;

	// per-stage load enables shared with the distance units
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// ===== hw/rtl/ccc_ref_unit.sv =====
`timescale 1ns / 1ps

// L1 distance of the pixel chromaticity to one reference, scaled by the sum.
// s2: reference products, s3: absolute differences added.
module ccc_ref_unit #(
	parameter int REF_FRAC_BITS = 10
) (
	input  logic                                clk,
	input  ccc_pkg::stage_en_t                  en,
	input  logic [ccc_pkg::SUM_W-1:0]           sum_s1,
	input  logic [ccc_pkg::CH_W-1:0]            blue_s1,
	input  logic [ccc_pkg::CH_W-1:0]            green_s1,
	input  logic [2*REF_FRAC_BITS-1:0]          ref_val,
	output logic [REF_FRAC_BITS+ccc_pkg::SUM_W:0] dist_s3
);

	localparam int F     = REF_FRAC_BITS;
	localparam int PW    = F + ccc_pkg::CH_W;   // shifted pixel channel
	localparam int RW    = F + ccc_pkg::SUM_W;  // reference times sum
	localparam int DW    = RW + 1;              // signed difference / distance

	logic [F-1:0]  ref_b;
	logic [F-1:0]  ref_g;
	logic [PW-1:0] pix_b_s2;
	logic [PW-1:0] pix_g_s2;
	logic [RW-1:0] prod_b_s2;
	logic [RW-1:0] prod_g_s2;
	logic signed [DW-1:0] diff_b;
	logic signed [DW-1:0] diff_g;
	logic [DW-1:0] abs_b;
	logic [DW-1:0] abs_g;

	assign ref_b = ref_val[2*F-1:F];
	assign ref_g = ref_val[F-1:0];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pix_b_s2  <= {blue_s1, {F{1'b0}}};
			pix_g_s2  <= {green_s1, {F{1'b0}}};
			prod_b_s2 <= RW'(ref_b) * RW'(sum_s1);
			prod_g_s2 <= RW'(ref_g) * RW'(sum_s1);
		end
	end

	always_comb begin
		diff_b = $signed({3'b000, pix_b_s2}) - $signed({1'b0, prod_b_s2});
		diff_g = $signed({3'b000, pix_g_s2}) - $signed({1'b0, prod_g_s2});
		abs_b  = diff_b[DW-1] ? DW'(-diff_b) : DW'(diff_b);
		abs_g  = diff_g[DW-1] ? DW'(-diff_g) : DW'(diff_g);
	end

	// each magnitude is below 2^RW, so the sum fits in DW bits
	always_ff @(posedge clk) begin
		if (en.s3) begin
			dist_s3 <= abs_b + abs_g;
		end
	end

endmodule

// ===== hw/rtl/chromaticity_color_classifier.sv =====
`timescale 1ns / 1ps

// Chromaticity color classifier.
// Input channel (in_valid/in_ready): one BGR pixel plus seed_mode per
// transaction. Output channel (out_valid/out_ready): marker_class (first of
// three markers whose chromaticity L1 distance is below the active
// threshold, 0 for none) and joint_match. seed_mode picks seed_threshold
// over grow_threshold for the markers. A black pixel matches nothing.
// Config: write_en/write_index/write_data, one register per cycle, no
// read-back; write only while the pipeline is empty.
// Throughput: one pixel per cycle while out_ready holds. Latency: four register
// stages (sum, reference products, distances, compare); out_valid is the last
// stage's valid bit.
// Reset: all stage valid bits clear and the configuration registers take their defaults.
// Stall: each stage holds while its successor is full and stalled; bubbles
// are squeezed out, so in_ready stays high until every stage is occupied
// behind a stalled output.
module chromaticity_color_classifier #(
	parameter int REF_FRAC_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         write_en,
	input  logic [ccc_pkg::REG_IDX_W-1:0] write_index,
	input  logic [2*REF_FRAC_BITS-1:0]   write_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ccc_pkg::CH_W-1:0]     blue,
	input  logic [ccc_pkg::CH_W-1:0]     green,
	input  logic [ccc_pkg::CH_W-1:0]     red,
	input  logic                         seed_mode,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ccc_pkg::CLS_W-1:0]    marker_class,
	output logic                         joint_match
);

	localparam int F   = REF_FRAC_BITS;
	localparam int RFW = 2 * F;
	localparam int DW  = F + ccc_pkg::SUM_W + 1;
	localparam int TW  = ccc_pkg::PROD_THR_W;
	localparam int CW  = (DW > TW) ? DW : TW;

	// ---------------- configuration registers ----------------
	logic [RFW-1:0]                marker_one_q;
	logic [RFW-1:0]                marker_two_q;
	logic [RFW-1:0]                marker_three_q;
	logic [RFW-1:0]                joint_ref_q;
	logic [ccc_pkg::THR_W-1:0]     grow_thr_q;
	logic [ccc_pkg::THR_W-1:0]     seed_thr_q;
	logic [ccc_pkg::THR_W-1:0]     joint_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_one_q   <= ccc_pkg::RST_MARKER_ONE[RFW-1:0];
			marker_two_q   <= ccc_pkg::RST_MARKER_TWO[RFW-1:0];
			marker_three_q <= ccc_pkg::RST_MARKER_THREE[RFW-1:0];
			joint_ref_q    <= ccc_pkg::RST_JOINT_REF[RFW-1:0];
			grow_thr_q     <= ccc_pkg::RST_GROW_THR;
			seed_thr_q     <= ccc_pkg::RST_SEED_THR;
			joint_thr_q    <= ccc_pkg::RST_JOINT_THR;
		end else if (write_en) begin
			unique case (write_index)
				ccc_pkg::REG_MARKER_ONE:   marker_one_q   <= write_data;
				ccc_pkg::REG_MARKER_TWO:   marker_two_q   <= write_data;
				ccc_pkg::REG_MARKER_THREE: marker_three_q <= write_data;
				ccc_pkg::REG_JOINT_REF:    joint_ref_q    <= write_data;
				ccc_pkg::REG_GROW_THR:     grow_thr_q <= write_data[ccc_pkg::THR_W-1:0];
				ccc_pkg::REG_SEED_THR:     seed_thr_q <= write_data[ccc_pkg::THR_W-1:0];
				ccc_pkg::REG_JOINT_THR:    joint_thr_q <= write_data[ccc_pkg::THR_W-1:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	// A stage loads when it is empty or its successor moves on.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	ccc_pkg::stage_en_t en;
	logic en_s1, en_s4;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign en_s1 = rdy1 && in_valid;
	assign en.s2 = rdy2 && v_s1;
	assign en.s3 = rdy3 && v_s2;
	assign en_s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: sum and threshold select ----------------
	logic [ccc_pkg::SUM_W-1:0] sum_s1;
	logic [ccc_pkg::CH_W-1:0]  blue_s1;
	logic [ccc_pkg::CH_W-1:0]  green_s1;
	logic [ccc_pkg::THR_W-1:0] thr_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sum_s1   <= ccc_pkg::SUM_W'(blue) + ccc_pkg::SUM_W'(green)
				+ ccc_pkg::SUM_W'(red);
			blue_s1  <= blue;
			green_s1 <= green;
			thr_s1   <= seed_mode ? seed_thr_q : grow_thr_q;
		end
	end

	// ---------------- stage 2/3: threshold limits scaled by the sum ----------------
	logic [TW-1:0] lim_s2, jlim_s2;
	logic [TW-1:0] lim_s3, jlim_s3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			lim_s2  <= TW'(thr_s1) * TW'(sum_s1);
			jlim_s2 <= TW'(joint_thr_q) * TW'(sum_s1);
		end
		if (en.s3) begin
			lim_s3  <= lim_s2;
			jlim_s3 <= jlim_s2;
		end
	end

	// ---------------- stage 2/3: distance units ----------------
	logic [DW-1:0] dist_one_s3, dist_two_s3, dist_three_s3, dist_joint_s3;

	ccc_ref_unit #(.REF_FRAC_BITS(F)) u_ref_one (
		.clk(clk), .en(en), .sum_s1(sum_s1), .blue_s1(blue_s1),
		.green_s1(green_s1), .ref_val(marker_one_q), .dist_s3(dist_one_s3)
	);

	ccc_ref_unit #(.REF_FRAC_BITS(F)) u_ref_two (
		.clk(clk), .en(en), .sum_s1(sum_s1), .blue_s1(blue_s1),
		.green_s1(green_s1), .ref_val(marker_two_q), .dist_s3(dist_two_s3)
	);

	ccc_ref_unit #(.REF_FRAC_BITS(F)) u_ref_three (
		.clk(clk), .en(en), .sum_s1(sum_s1), .blue_s1(blue_s1),
		.green_s1(green_s1), .ref_val(marker_three_q), .dist_s3(dist_three_s3)
	);

	ccc_ref_unit #(.REF_FRAC_BITS(F)) u_ref_joint (
		.clk(clk), .en(en), .sum_s1(sum_s1), .blue_s1(blue_s1),
		.green_s1(green_s1), .ref_val(joint_ref_q), .dist_s3(dist_joint_s3)
	);

	// ---------------- stage 4: compare, priority, output register ----------------
	// A black pixel gives zero distance and zero limit, so strict compare
	// already rejects it.
	logic hit_one, hit_two, hit_three, hit_joint;
	logic [ccc_pkg::CLS_W-1:0] cls_nxt;
	logic [ccc_pkg::CLS_W-1:0] class_s4;
	logic                      joint_s4;

	always_comb begin
		hit_one   = CW'(dist_one_s3)   < CW'(lim_s3);
		hit_two   = CW'(dist_two_s3)   < CW'(lim_s3);
		hit_three = CW'(dist_three_s3) < CW'(lim_s3);
		hit_joint = CW'(dist_joint_s3) < CW'(jlim_s3);
		if (hit_one)        cls_nxt = ccc_pkg::CLS_ONE;
		else if (hit_two)   cls_nxt = ccc_pkg::CLS_TWO;
		else if (hit_three) cls_nxt = ccc_pkg::CLS_THREE;
		else                cls_nxt = ccc_pkg::CLS_NONE;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			class_s4 <= cls_nxt;
			joint_s4 <= hit_joint;
		end
	end

	assign out_valid    = v_s4;
	assign marker_class = class_s4;
	assign joint_match  = joint_s4;

`ifndef SYNTH
	// an empty output stage means nothing can block the input
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with output stage empty");

	// input may only stall once every stage is full behind a stalled output
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && out_valid && !out_ready))
		else $error("input stalled with a free stage");

	// a stalled output must not drop the transaction waiting behind it
	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && v_s3) |=> v_s3)
		else $error("stage 3 transaction lost during stall");
`endif

endmodule
